// ----- design/srle_pkg.sv -----
package srle_pkg;

	localparam int POS_W = 13;
	localparam logic [POS_W-1:0] LINE_LEN_MAX = 13'd4096;
	localparam int WORD_DEPTH = 8;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	// region kinds
	localparam logic [2:0] KIND_KEYWORD = 3'd0;
	localparam logic [2:0] KIND_TYPE    = 3'd1;
	localparam logic [2:0] KIND_COMMENT = 3'd2;
	localparam logic [2:0] KIND_STRING  = 3'd3;
	localparam logic [2:0] KIND_NUMBER  = 3'd4;
	localparam logic [2:0] KIND_PREPROC = 3'd5;
	localparam logic [2:0] KIND_MARKER  = 3'd6;

	// word match classes
	localparam logic [1:0] WC_NONE = 2'd0;
	localparam logic [1:0] WC_KW   = 2'd1;
	localparam logic [1:0] WC_TYPE = 2'd2;

	typedef logic [WORD_DEPTH-1:0][7:0] word_t;

	typedef struct packed {
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] stop;
		logic [2:0]       kind;
		logic [7:0]       count;
	} region_t;

	typedef struct packed {
		logic [1:0] num;
		region_t    r1;
		region_t    r0;
	} bundle_t;

	localparam word_t KW_TAB [19] = '{
		{"break", 24'h0}, {"case", 32'h0}, {"continue"}, {"default", 8'h0},
		{"do", 48'h0}, {"else", 32'h0}, {"extern", 16'h0}, {"for", 40'h0},
		{"goto", 32'h0}, {"if", 48'h0}, {"inline", 16'h0}, {"register"},
		{"return", 16'h0}, {"sizeof", 16'h0}, {"static", 16'h0},
		{"switch", 16'h0}, {"typedef", 8'h0}, {"volatile"}, {"while", 24'h0}
	};

	localparam word_t TYPE_TAB [14] = '{
		{"auto", 32'h0}, {"char", 32'h0}, {"const", 24'h0}, {"double", 16'h0},
		{"enum", 32'h0}, {"float", 24'h0}, {"int", 40'h0}, {"long", 32'h0},
		{"short", 24'h0}, {"signed", 16'h0}, {"struct", 16'h0}, {"union", 24'h0},
		{"unsigned"}, {"void", 32'h0}
	};

	// parallel compare against both word sets, chars left-justified, zero padded
	function automatic logic [1:0] word_class(input word_t w);
		logic [1:0] r;
		r = WC_NONE;
		for (int i = 0; i < 14; i++) begin
			if (w == TYPE_TAB[i]) r = WC_TYPE;
		end
		for (int i = 0; i < 19; i++) begin
			if (w == KW_TAB[i]) r = WC_KW;
		end
		return r;
	endfunction

endpackage

// ----- design/srle_front.sv -----
module srle_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    q_full,
	input  logic [20:0]             code_point,
	input  logic                    line_end,
	input  logic                    cfg_write,
	input  logic [7:0]              cfg_data,
	output logic                    push,
	output srle_pkg::bundle_t       push_data
);

	typedef enum logic [6:0] {
		M_IDLE    = 7'b0000001,
		M_IDENT   = 7'b0000010,
		M_NUMBER  = 7'b0000100,
		M_STRING  = 7'b0001000,
		M_BLOCK   = 7'b0010000,
		M_LINECOM = 7'b0100000,
		M_PREPROC = 7'b1000000
	} mode_t;

	typedef enum logic [6:0] {
		P_ZERO    = 7'b0000001,
		P_INT     = 7'b0000010,
		P_FRAC    = 7'b0000100,
		P_EXPSIGN = 7'b0001000,
		P_EXP     = 7'b0010000,
		P_HEX     = 7'b0100000,
		P_SUFFIX  = 7'b1000000
	} phase_t;

	typedef enum logic [2:0] {
		LA_NONE  = 3'b001,
		LA_SLASH = 3'b010,
		LA_DOT   = 3'b100
	} la_t;

	localparam int PW = srle_pkg::POS_W;

	mode_t             mode_q, mode_d;
	phase_t            phase_q, phase_d, ph_eff, phase_n;
	la_t               la_q, la_d;
	logic [PW-1:0]     lpos_q, lpos_d, tstart_q, tstart_d, pos1;
	logic              qsingle_q, qsingle_d, esc_q, esc_d, star_q, star_d;
	srle_pkg::word_t   word_q, word_d;
	logic [3:0]        wlen_q, wlen_d;
	logic              wlong_q, wlong_d;
	logic [7:0]        rcount_q, cnt;
	logic              atstart_q, atstart_d, done_q, done_d;
	logic [7:0]        max_q;
	logic              accept, go, take, emitted;
	logic [1:0]        hit;
	logic [20:0]       cf;
	logic              is_dig, is_alp, is_idc, is_xd;
	srle_pkg::region_t reg0, marker;
	srle_pkg::bundle_t bnd;

	assign accept = in_valid && !q_full;
	assign cf = code_point | 21'h20;
	assign is_dig = code_point inside {[21'h30:21'h39]};
	assign is_alp = (code_point inside {[21'h41:21'h5A]}) || (code_point inside {[21'h61:21'h7A]});
	assign is_idc = is_alp || is_dig || (code_point == 21'h5F);
	assign is_xd = is_dig || (cf inside {[21'h61:21'h66]});
	assign hit = srle_pkg::word_class(word_q);
	assign pos1 = (lpos_q < srle_pkg::LINE_LEN_MAX) ? lpos_q + 1'b1 : lpos_q;

	// number continuation
	always_comb begin
		take = 1'b0;
		phase_d = phase_q;
		ph_eff = (phase_q == P_ZERO) ? P_INT : phase_q;
		if (phase_q == P_ZERO && cf == 21'h78) begin
			take = 1'b1;
			phase_d = P_HEX;
		end else begin
			case (ph_eff)
				P_INT: begin
					if (is_dig) begin
						take = 1'b1; phase_d = P_INT;
					end else if (code_point == 21'h2E) begin
						take = 1'b1; phase_d = P_FRAC;
					end else if (cf == 21'h65) begin
						take = 1'b1; phase_d = P_EXPSIGN;
					end
				end
				P_FRAC: begin
					if (is_dig) begin
						take = 1'b1;
					end else if (cf == 21'h65) begin
						take = 1'b1; phase_d = P_EXPSIGN;
					end
				end
				P_EXPSIGN: begin
					if (code_point == 21'h2B || code_point == 21'h2D || is_dig) begin
						take = 1'b1; phase_d = P_EXP;
					end
				end
				P_EXP: if (is_dig) take = 1'b1;
				P_HEX: if (is_xd) take = 1'b1;
				default: ;
			endcase
			if (!take && (cf == 21'h75 || cf == 21'h6C || cf == 21'h66)) begin
				take = 1'b1;
				phase_d = P_SUFFIX;
			end
		end
	end

	// per-character lexing and terminator handling
	always_comb begin
		mode_d = mode_q; la_d = la_q; lpos_d = lpos_q; tstart_d = tstart_q;
		qsingle_d = qsingle_q; esc_d = esc_q; star_d = star_q; word_d = word_q;
		wlen_d = wlen_q; wlong_d = wlong_q; atstart_d = atstart_q; done_d = done_q;
		cnt = rcount_q; go = 1'b0; emitted = 1'b0; reg0 = '0; marker = '0;
		bnd = '0;
		if (!line_end) begin
			lpos_d = pos1;
			if (!done_q) begin
				if (rcount_q >= max_q) begin
					done_d = 1'b1; mode_d = M_IDLE; la_d = LA_NONE;
				end else begin
					case (mode_q)
						M_IDENT: begin
							if (is_idc) begin
								if (wlen_q < 4'(srle_pkg::WORD_DEPTH)) begin
									word_d[3'd7 - wlen_q[2:0]] = {1'b0, code_point[6:0]};
									wlen_d = wlen_q + 4'd1;
								end else begin
									wlong_d = 1'b1;
								end
							end else begin
								if (!wlong_q && wlen_q != 4'd0 && hit != srle_pkg::WC_NONE) begin
									emitted = 1'b1;
									reg0.kind = (hit == srle_pkg::WC_KW) ?
										srle_pkg::KIND_KEYWORD : srle_pkg::KIND_TYPE;
									reg0.start = tstart_q; reg0.stop = lpos_q;
								end
								mode_d = M_IDLE; go = 1'b1;
							end
						end
						M_NUMBER: begin
							if (!take) begin
								emitted = 1'b1; reg0.kind = srle_pkg::KIND_NUMBER;
								reg0.start = tstart_q; reg0.stop = lpos_q;
								mode_d = M_IDLE; go = 1'b1;
							end
						end
						M_STRING: begin
							if (esc_q) begin
								esc_d = 1'b0;
							end else if (code_point == 21'h5C) begin
								esc_d = 1'b1;
							end else if (code_point == (qsingle_q ? 21'h27 : 21'h22)) begin
								mode_d = M_IDLE; emitted = 1'b1;
								reg0.kind = srle_pkg::KIND_STRING;
								reg0.start = tstart_q; reg0.stop = pos1;
							end
						end
						M_BLOCK: begin
							if (star_q && code_point == 21'h2F) begin
								mode_d = M_IDLE; emitted = 1'b1;
								reg0.kind = srle_pkg::KIND_COMMENT;
								reg0.start = tstart_q; reg0.stop = pos1;
							end else begin
								star_d = (code_point == 21'h2A);
							end
						end
						M_LINECOM, M_PREPROC: ;
						default: begin
							mode_d = M_IDLE; go = 1'b1;
						end
					endcase
					// start of a new token
					if (go) begin
						la_d = LA_NONE;
						if (la_q == LA_SLASH && code_point == 21'h2F) begin
							mode_d = M_LINECOM;
						end else if (la_q == LA_SLASH && code_point == 21'h2A) begin
							mode_d = M_BLOCK; star_d = 1'b0;
						end else if (la_q == LA_DOT && is_dig) begin
							mode_d = M_NUMBER;
						end else if (code_point == 21'h20 || code_point == 21'h09) begin
						end else if (code_point == 21'h23 && atstart_q) begin
							mode_d = M_PREPROC; tstart_d = lpos_q;
						end else begin
							atstart_d = 1'b0;
							if (code_point == 21'h2F) begin
								la_d = LA_SLASH; tstart_d = lpos_q;
							end else if (code_point == 21'h22 || code_point == 21'h27) begin
								mode_d = M_STRING; tstart_d = lpos_q;
								qsingle_d = (code_point == 21'h27); esc_d = 1'b0;
							end else if (is_dig) begin
								mode_d = M_NUMBER; tstart_d = lpos_q;
							end else if (code_point == 21'h2E) begin
								la_d = LA_DOT; tstart_d = lpos_q;
							end else if (is_alp || code_point == 21'h5F) begin
								mode_d = M_IDENT; tstart_d = lpos_q;
								wlen_d = 4'd1; wlong_d = 1'b0;
								word_d = '0;
								word_d[7] = {1'b0, code_point[6:0]};
							end
						end
					end
				end
			end
			if (emitted) begin
				cnt = rcount_q + 8'd1;
				reg0.count = cnt;
			end
			bnd.num = {1'b0, emitted};
			bnd.r0 = reg0;
		end else begin
			if (!done_q && rcount_q < max_q) begin
				reg0.start = tstart_q; reg0.stop = lpos_q;
				case (mode_q)
					M_IDENT: begin
						if (!wlong_q && wlen_q != 4'd0 && hit != srle_pkg::WC_NONE) begin
							emitted = 1'b1;
							reg0.kind = (hit == srle_pkg::WC_KW) ?
								srle_pkg::KIND_KEYWORD : srle_pkg::KIND_TYPE;
						end
					end
					M_NUMBER: begin
						emitted = 1'b1; reg0.kind = srle_pkg::KIND_NUMBER;
					end
					M_STRING: begin
						emitted = 1'b1; reg0.kind = srle_pkg::KIND_STRING;
					end
					M_BLOCK, M_LINECOM: begin
						emitted = 1'b1; reg0.kind = srle_pkg::KIND_COMMENT;
					end
					M_PREPROC: begin
						emitted = 1'b1; reg0.kind = srle_pkg::KIND_PREPROC;
					end
					default: ;
				endcase
			end
			if (emitted) begin
				cnt = rcount_q + 8'd1;
				reg0.count = cnt;
			end
			marker.start = '0; marker.stop = lpos_q;
			marker.kind = srle_pkg::KIND_MARKER; marker.count = cnt;
			if (emitted) begin
				bnd.num = 2'd2; bnd.r0 = reg0; bnd.r1 = marker;
			end else begin
				bnd.num = 2'd1; bnd.r0 = marker;
			end
			// ready for the next line
			mode_d = M_IDLE; la_d = LA_NONE; lpos_d = '0; tstart_d = '0;
			qsingle_d = 1'b0; esc_d = 1'b0; star_d = 1'b0; wlen_d = 4'd0;
			wlong_d = 1'b0; cnt = 8'd0; atstart_d = 1'b1; done_d = 1'b0;
		end
	end

	// number phase: continue, or start afresh (dot followed by digit enters the fraction)
	always_comb begin
		phase_n = phase_q;
		if (line_end) begin
			phase_n = P_ZERO;
		end else if (!done_q && rcount_q < max_q) begin
			if (mode_q == M_NUMBER && take) begin
				phase_n = phase_d;
			end else if (go && mode_d == M_NUMBER) begin
				if (la_q == LA_DOT) phase_n = P_FRAC;
				else phase_n = (code_point == 21'h30) ? P_ZERO : P_INT;
			end
		end
	end

	assign push = accept && (bnd.num != 2'd0);
	assign push_data = bnd;

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; phase_q <= P_ZERO; la_q <= LA_NONE;
			lpos_q <= '0; tstart_q <= '0; qsingle_q <= 1'b0; esc_q <= 1'b0;
			star_q <= 1'b0; wlen_q <= 4'd0; wlong_q <= 1'b0; rcount_q <= 8'd0;
			atstart_q <= 1'b1; done_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d; phase_q <= phase_n; la_q <= la_d;
			lpos_q <= lpos_d; tstart_q <= tstart_d; qsingle_q <= qsingle_d;
			esc_q <= esc_d; star_q <= star_d; wlen_q <= wlen_d; wlong_q <= wlong_d;
			rcount_q <= cnt; atstart_q <= atstart_d; done_q <= done_d;
		end
	end

	// word buffer
	always_ff @(posedge clk) begin
		if (accept) word_q <= word_d;
	end

	// region limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 8'd64;
		end else if (cfg_write) begin
			max_q <= cfg_data;
		end
	end

endmodule

// ----- design/srle_fifo.sv -----
module srle_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  srle_pkg::bundle_t push_data,
	input  logic              pop,
	output srle_pkg::bundle_t head,
	output logic              full,
	output logic              empty
);

	srle_pkg::bundle_t         mem_q [srle_pkg::QDEPTH];
	logic [srle_pkg::QAW-1:0]  wptr_q, rptr_q;
	logic [srle_pkg::QAW:0]    count_q;

	assign full = (count_q == (srle_pkg::QAW+1)'(srle_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0; rptr_q <= '0; count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (srle_pkg::QAW+1)'(push) - (srle_pkg::QAW+1)'(pop);
		end
	end

endmodule

// ----- design/srle_emit.sv -----
module srle_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  srle_pkg::bundle_t head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [12:0]       region_start,
	output logic [12:0]       region_end,
	output logic [2:0]        region_kind,
	output logic [7:0]        region_count,
	output logic              last
);

	logic              ov_q, sel_q, load, is_last;
	srle_pkg::region_t cur, out_q;
	logic              last_q;

	assign cur = sel_q ? head.r1 : head.r0;
	assign is_last = sel_q || (head.num == 2'd1);
	assign load = !empty && (!ov_q || !out_stall);
	assign pop = load && is_last;

	// result selection and hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0; sel_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
				sel_q <= !is_last;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= cur;
			last_q <= is_last;
		end
	end

	assign out_valid = ov_q;
	assign region_start = out_q.start;
	assign region_end = out_q.stop;
	assign region_kind = out_q.kind;
	assign region_count = out_q.count;
	assign last = last_q;

endmodule

// ----- design/c_syntax_region_lexer_core.sv -----
// path: a result is written into the result queue by the lexer, then registered in the output stage
// throughput: one character per cycle while in_stall is low; a line terminator with an open region
// yields two results, absorbed by the four-entry result queue between lexer and output stage
// reset: arst_n clears lexer state to line start, empties the queue, max_regions to 64
module c_syntax_region_lexer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [20:0] code_point,
	input  logic        line_end,
	input  logic        cfg_write,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] region_start,
	output logic [12:0] region_end,
	output logic [2:0]  region_kind,
	output logic [7:0]  region_count,
	output logic        last
);

	logic              push, pop, full, empty;
	srle_pkg::bundle_t push_data, head;

	assign in_stall = full;

	// lexer front end
	srle_front u_front (
		.clk, .arst_n, .in_valid, .q_full(full), .code_point, .line_end,
		.cfg_write, .cfg_data, .push, .push_data
	);

	// result queue
	srle_fifo u_fifo (
		.clk, .arst_n, .push, .push_data, .pop, .head, .full, .empty
	);

	// output stage
	srle_emit u_emit (
		.clk, .arst_n, .head, .empty, .pop, .out_valid, .out_stall,
		.region_start, .region_end, .region_kind, .region_count, .last
	);

endmodule

// ----- design/srle_checker.sv -----
module srle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [12:0] region_start,
	input logic [2:0]  region_kind,
	input logic [7:0]  region_count,
	input logic        last
);

	// a stalled transaction stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transaction dropped under stall");

	// line marker ends the item and starts at zero
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region_kind == srle_pkg::KIND_MARKER |-> last && region_start == 13'd0)
		else $error("malformed line marker");

	// every real region carries a non-zero running count
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region_kind != srle_pkg::KIND_MARKER |-> region_count != 8'd0)
		else $error("region with zero count");

	// no undefined kind code
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> region_kind != 3'd7)
		else $error("undefined region kind");

endmodule

bind c_syntax_region_lexer_core srle_checker u_srle_checker (
	.clk, .arst_n, .out_valid, .out_stall, .region_start, .region_kind,
	.region_count, .last
);
